FILE: design/rsti_pkg.sv
// Package for the radix numeral parser: shared constants, digit type and
// the character-to-digit decoder. No dependencies.
`timescale 1ns / 1ps

package rsti_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned RadixWidth = 6;
  localparam int unsigned CharWidth  = 8;

  localparam logic [RadixWidth-1:0] RadixReset = 6'd10;
  localparam logic [RadixWidth-1:0] MaxRadix   = 6'd36;
  localparam logic [CharWidth-1:0]  MinusSign  = 8'h2D;

  localparam logic [CharWidth-1:0] CharZero   = 8'h30;
  localparam logic [CharWidth-1:0] CharNine   = 8'h39;
  localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
  localparam logic [CharWidth-1:0] CharLowerZ = 8'h7A;
  localparam logic [CharWidth-1:0] CharUpperA = 8'h41;
  localparam logic [CharWidth-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharWidth-1:0] LetterBase = 8'd10;

  typedef struct packed {
    logic                  valid;
    logic [RadixWidth-1:0] digit;
  } digit_t;

  // Map a byte to 0..35, case-insensitive; flag anything else.
  function automatic digit_t char_to_digit(input logic [CharWidth-1:0] c);
    digit_t                r;
    logic [CharWidth-1:0]  diff;
    r    = '0;
    diff = '0;
    if (c >= CharZero && c <= CharNine) begin
      diff = c - CharZero;
      r.valid = 1'b1;
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      diff = c - CharLowerA + LetterBase;
      r.valid = 1'b1;
    end else if (c >= CharUpperA && c <= CharUpperZ) begin
      diff = c - CharUpperA + LetterBase;
      r.valid = 1'b1;
    end
    r.digit = diff[RadixWidth-1:0];
    return r;
  endfunction

endpackage

FILE: design/radix_string_to_integer_core.sv
// Radix numeral parser top level: input register, digit accumulate stage
// and result register. Depends on rsti_pkg.
// A result beat is loaded into the result register as the beat of its last
// character leaves the input register. Throughput: one character per cycle
// when in_stall_o is low; the radix multiply-add is combinational.
// Reset: asynchronous, active low; clears the stages, the numeral state and
// sets the radix to ten.
`timescale 1ns / 1ps

module radix_string_to_integer_core #(
  parameter int unsigned ValueWidth = rsti_pkg::ValueWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rsti_pkg::RadixWidth-1:0]     cfg_radix_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rsti_pkg::CharWidth-1:0]      character_i,
  input  logic                                last_char_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ValueWidth-1:0]        value_o,
  output logic                                bad_input_o,
  output logic                                overflowed_o
);

  localparam int unsigned RW = rsti_pkg::RadixWidth;
  localparam int unsigned PW = ValueWidth + RW;

  logic [RW-1:0]                    radix_q;
  logic                             s1_valid_q;
  logic [rsti_pkg::CharWidth-1:0]   s1_char_q;
  logic                             s1_last_q;
  logic [ValueWidth-1:0]            acc_q, acc_d;
  logic                             neg_q, neg_d;
  logic                             first_q, first_d;
  logic                             err_q, err_d;
  logic                             wrap_q, wrap_d;
  logic                             digits_q, digits_d;
  logic                             out_valid_q;
  logic [ValueWidth-1:0]            value_q, value_d;
  logic                             bad_q, bad_d;
  logic                             ovf_q;
  logic                             res_free, s1_adv, in_take;
  rsti_pkg::digit_t                 dig;
  logic [PW-1:0]                    sum;
  logic [ValueWidth-1:0]            acc_n;
  logic                             neg_n, err_n, wrap_n, digits_n;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rsti_pkg::RadixReset;
    end else if (cfg_valid_i) begin
      radix_q <= cfg_radix_i;
    end
  end

  assign res_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_last_q || res_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= character_i;
      s1_last_q <= last_char_i;
    end
  end

  assign dig = rsti_pkg::char_to_digit(s1_char_q);
  assign sum = ({{RW{1'b0}}, acc_q} * {{ValueWidth{1'b0}}, radix_q})
             + {{ValueWidth{1'b0}}, dig.digit};

  always_comb begin
    acc_n    = acc_q;
    neg_n    = neg_q;
    err_n    = err_q;
    wrap_n   = wrap_q;
    digits_n = digits_q;
    if (first_q && s1_char_q == rsti_pkg::MinusSign) begin
      neg_n = 1'b1;
    end else begin
      digits_n = 1'b1;
      if (!err_q) begin
        if (!dig.valid || dig.digit >= radix_q) begin
          err_n = 1'b1;
        end else begin
          acc_n = sum[ValueWidth-1:0];
          if (sum[PW-1:ValueWidth] != '0) begin
            wrap_n = 1'b1;
          end
        end
      end
    end

    bad_d   = err_n || !digits_n || (radix_q > rsti_pkg::MaxRadix);
    value_d = '0;
    if (!bad_d) begin
      value_d = neg_n ? (~acc_n + 1'b1) : acc_n;
    end

    if (s1_last_q) begin
      acc_d    = '0;
      neg_d    = 1'b0;
      first_d  = 1'b1;
      err_d    = 1'b0;
      wrap_d   = 1'b0;
      digits_d = 1'b0;
    end else begin
      acc_d    = acc_n;
      neg_d    = neg_n;
      first_d  = 1'b0;
      err_d    = err_n;
      wrap_d   = wrap_n;
      digits_d = digits_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      neg_q    <= 1'b0;
      first_q  <= 1'b1;
      err_q    <= 1'b0;
      wrap_q   <= 1'b0;
      digits_q <= 1'b0;
    end else if (s1_adv) begin
      acc_q    <= acc_d;
      neg_q    <= neg_d;
      first_q  <= first_d;
      err_q    <= err_d;
      wrap_q   <= wrap_d;
      digits_q <= digits_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      value_q <= value_d;
      bad_q   <= bad_d;
      ovf_q   <= wrap_n;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign bad_input_o  = bad_q;
  assign overflowed_o = ovf_q;

endmodule
